### design/fpa_pkg.sv
`timescale 1ns / 1ps
// Package for the fixed-point ALU: widths, operation codes, pipeline stage record
// and the saturation helper. No dependencies.
package fpa_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 8;

  typedef logic [3:0] func_t;
  localparam func_t FN_ADD  = 4'd0;
  localparam func_t FN_SUB  = 4'd1;
  localparam func_t FN_MUL  = 4'd2;
  localparam func_t FN_DIV  = 4'd3;
  localparam func_t FN_CMP  = 4'd4;
  localparam func_t FN_MIN  = 4'd5;
  localparam func_t FN_MAX  = 4'd6;
  localparam func_t FN_INC  = 4'd7;
  localparam func_t FN_DEC  = 4'd8;
  localparam func_t FN_FINT = 4'd9;
  localparam func_t FN_TINT = 4'd10;

  typedef struct packed {
    logic                  valid;
    func_t                 func;
    logic                  neg;    // result sign for mul and div
    logic                  dz;     // zero divisor
    logic                  ovf;    // quotient does not fit 32 bits
    logic [DATA_W-1:0]     ma;     // |a|
    logic [DATA_W-1:0]     d;      // |b|
    logic [DATA_W-1:0]     rem;    // partial remainder
    logic [DATA_W-1:0]     nlo;    // dividend bits still to bring down
    logic [DATA_W-1:0]     quo;    // quotient bits so far
    logic [2*DATA_W-1:0]   prod;   // exact |a|*|b|
    logic [DATA_W-1:0]     res;    // result of the simple operations
    logic                  lt;
    logic                  eq;
    logic                  gt;
  } stage_t;

  // Apply sign to a magnitude and clamp to the signed 32-bit range.
  function automatic logic [DATA_W-1:0] sat_signed(input logic neg,
                                                   input logic [2*DATA_W-1:0] m);
    logic [2*DATA_W-1:0] lim;
    logic [2*DATA_W-1:0] mm;
    lim = {{DATA_W{1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};
    if (!neg) begin
      sat_signed = (m >= lim) ? {1'b0, {(DATA_W-1){1'b1}}} : m[DATA_W-1:0];
    end else begin
      mm = (m > lim) ? lim : m;
      sat_signed = DATA_W'(~mm[DATA_W-1:0] + 1'b1);
    end
  endfunction

endpackage

### design/fpa_in_if.sv
`timescale 1ns / 1ps
// Operation channel of the fixed-point ALU.
// Depends on fpa_pkg.
interface fpa_in_if;
  logic                        valid;
  logic                        ready;
  logic [3:0]                  func;
  logic signed [fpa_pkg::DATA_W-1:0] operand_a;
  logic signed [fpa_pkg::DATA_W-1:0] operand_b;
  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

### design/fpa_out_if.sv
`timescale 1ns / 1ps
// Result channel of the fixed-point ALU.
// Depends on fpa_pkg.
interface fpa_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [fpa_pkg::DATA_W-1:0] result_value;
  logic                        less_flag;
  logic                        equal_flag;
  logic                        greater_flag;
  logic                        divide_by_zero;
  modport source (output valid, result_value, less_flag, equal_flag, greater_flag,
                  divide_by_zero, input ready);
  modport sink   (input valid, result_value, less_flag, equal_flag, greater_flag,
                  divide_by_zero, output ready);
endinterface

### design/fixed_point_alu_top.sv
`timescale 1ns / 1ps
// Fixed-point ALU top level: pipelined add/sub/mul/div/compare, min/max, inc/dec and conversions.
// Depends on fpa_pkg, fpa_in_if and fpa_out_if.
//
// Usage:
//  - op channel (sink): one transfer carries func, operand_a and operand_b.
//  - res channel (source): one transfer per operation, in order, carrying the
//    32-bit result and the less/equal/greater/divide_by_zero flags.
//  - Between op transfer and res valid lie 34 registers: the input register
//    (loaded at the transfer edge), 32 restoring-division stages (one quotient
//    bit each) and the rounding/saturation output register. Every operation
//    takes this path.
//  - Throughput is one operation per cycle while the receiver takes results;
//    the division stages set the depth. The product |a|*|b| is formed in the
//    first division stage and carried. When the receiver stalls with a result
//    waiting, the whole pipe holds and op.ready drops; while the output
//    register is empty or being drained, the pipe advances and op.ready stays high, so nothing is lost or repeated.
//  - Synchronous reset clears all valid bits; the data registers are not reset.
//  - FRAC_BITS (1..30) is the number of fraction bits, Q24.8 by default.
module fixed_point_alu_top #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fpa_in_if.sink      op,
  fpa_out_if.source   res
);

  localparam int W     = fpa_pkg::DATA_W;
  localparam int NSTEP = W;

  fpa_pkg::stage_t stg [0:NSTEP];
  logic            en;

  // Pipe advances when the output register is free or being taken.
  assign en       = !res.valid || res.ready;
  assign op.ready = en;

  // Input stage: magnitudes, division set-up and the single-cycle operations.
  logic [W-1:0]   a_u, b_u, ma_c, mb_c;
  logic [2*W-1:0] n_c;
  logic [W-1:0]   simple_c;
  logic           lt_c, eq_c, gt_c;

  always_comb begin
    a_u  = op.operand_a;
    b_u  = op.operand_b;
    ma_c = a_u[W-1] ? W'(~a_u + 1'b1) : a_u;
    mb_c = b_u[W-1] ? W'(~b_u + 1'b1) : b_u;
    n_c  = {{W{1'b0}}, ma_c} << FRAC_BITS;
    lt_c = op.operand_a < op.operand_b;
    eq_c = op.operand_a == op.operand_b;
    gt_c = op.operand_a > op.operand_b;
    case (op.func)
      fpa_pkg::FN_ADD:  simple_c = W'(a_u + b_u);
      fpa_pkg::FN_SUB:  simple_c = W'(a_u - b_u);
      fpa_pkg::FN_MIN:  simple_c = lt_c ? a_u : b_u;
      fpa_pkg::FN_MAX:  simple_c = gt_c ? a_u : b_u;
      fpa_pkg::FN_INC:  simple_c = W'(a_u + 1'b1);
      fpa_pkg::FN_DEC:  simple_c = W'(a_u - 1'b1);
      fpa_pkg::FN_FINT: simple_c = a_u << FRAC_BITS;
      fpa_pkg::FN_TINT: simple_c = W'(op.operand_a >>> FRAC_BITS);
      default:          simple_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].valid <= 1'b0;
    end else if (en) begin
      stg[0].valid <= op.valid;
    end
    if (en) begin
      stg[0].func <= op.func;
      stg[0].neg  <= a_u[W-1] ^ b_u[W-1];
      stg[0].dz   <= (b_u == '0);
      // Quotient would need more than 32 bits: saturates anyway.
      stg[0].ovf  <= (n_c[2*W-1:W] >= mb_c);
      stg[0].ma   <= ma_c;
      stg[0].d    <= mb_c;
      stg[0].rem  <= n_c[2*W-1:W];
      stg[0].nlo  <= n_c[W-1:0];
      stg[0].quo  <= '0;
      stg[0].prod <= '0;
      stg[0].res  <= simple_c;
      stg[0].lt   <= (op.func == fpa_pkg::FN_CMP) && lt_c;
      stg[0].eq   <= (op.func == fpa_pkg::FN_CMP) && eq_c;
      stg[0].gt   <= (op.func == fpa_pkg::FN_CMP) && gt_c;
    end
  end

  // Restoring division, one quotient bit per stage, MSB first.
  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    logic [W:0] rsh;
    logic       ge;
    assign rsh = {stg[k-1].rem, stg[k-1].nlo[W-1]};
    assign ge  = rsh >= {1'b0, stg[k-1].d};

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k].valid <= 1'b0;
      end else if (en) begin
        stg[k].valid <= stg[k-1].valid;
      end
      if (en) begin
        stg[k].func <= stg[k-1].func;
        stg[k].neg  <= stg[k-1].neg;
        stg[k].dz   <= stg[k-1].dz;
        stg[k].ovf  <= stg[k-1].ovf;
        stg[k].ma   <= stg[k-1].ma;
        stg[k].d    <= stg[k-1].d;
        stg[k].rem  <= ge ? W'(rsh - {1'b0, stg[k-1].d}) : rsh[W-1:0];
        stg[k].nlo  <= {stg[k-1].nlo[W-2:0], 1'b0};
        stg[k].quo  <= {stg[k-1].quo[W-2:0], ge};
        // 32x32 product formed once, in the first step stage.
        stg[k].prod <= (k == 1) ? stg[k-1].ma * stg[k-1].d : stg[k-1].prod;
        stg[k].res  <= stg[k-1].res;
        stg[k].lt   <= stg[k-1].lt;
        stg[k].eq   <= stg[k-1].eq;
        stg[k].gt   <= stg[k-1].gt;
      end
    end
  end

  // Rounding (half away from zero on magnitudes) and saturation.
  fpa_pkg::stage_t s;
  logic [2*W-1:0]  qm, qd;
  logic [W-1:0]    fin;
  logic            rnd_d;

  always_comb begin
    s     = stg[NSTEP];
    qm    = (s.prod >> FRAC_BITS) + (2*W)'(s.prod[FRAC_BITS-1]);
    rnd_d = {s.rem, 1'b0} >= {1'b0, s.d};
    qd    = s.ovf ? {2*W{1'b1}} : (2*W)'({1'b0, s.quo} + (W+1)'(rnd_d));
    case (s.func)
      fpa_pkg::FN_MUL: fin = fpa_pkg::sat_signed(s.neg, qm);
      fpa_pkg::FN_DIV: fin = s.dz ? '0 : fpa_pkg::sat_signed(s.neg, qd);
      default:         fin = s.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= s.valid;
    end
    if (en) begin
      res.result_value   <= fin;
      res.less_flag      <= s.lt;
      res.equal_flag     <= s.eq;
      res.greater_flag   <= s.gt;
      res.divide_by_zero <= (s.func == fpa_pkg::FN_DIV) && s.dz;
    end
  end

endmodule

### design/fpa_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the fixed-point ALU, bound to the top level.
// Depends on fixed_point_alu_top.
module fpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_value,
  input logic        less_flag,
  input logic        equal_flag,
  input logic        greater_flag,
  input logic        divide_by_zero
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value))
    else $error("result changed while stalled");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({less_flag, equal_flag, greater_flag}))
    else $error("compare flags not exclusive");

  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (less_flag || equal_flag || greater_flag) |->
      result_value == 32'd0 && !divide_by_zero)
    else $error("compare result not zero");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> result_value == 32'd0)
    else $error("divide by zero result not zero");

endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .result_value  (res.result_value),
  .less_flag     (res.less_flag),
  .equal_flag    (res.equal_flag),
  .greater_flag  (res.greater_flag),
  .divide_by_zero(res.divide_by_zero)
);
